// ----- hw/rtl/i2c_command_transaction_master_defines.svh -----
// Assertion macros shared by the I2C command transaction master RTL.
// Every macro assumes that clk and rst_n are visible where it is used.
`ifndef I2C_COMMAND_TRANSACTION_MASTER_DEFINES_SVH
`define I2C_COMMAND_TRANSACTION_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master package
// Item types and address byte constants for the I2C command transaction master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int WORD_W = 13;

    localparam logic [7:0] ADDR_MASK = 8'h3E;
    localparam logic [7:0] ADDR_BASE = 8'h40;
    localparam logic [7:0] READ_FLAG = 8'h01;

    typedef struct packed {
        logic              start_req;
        logic              command;
        logic [WORD_W-1:0] command_word;
        logic              sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } out_item_t;

endpackage

// ----- hw/rtl/i2cm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick input channel
// Valid/ready channel that carries one bus tick item.
// ----------------------------------------------------------------------------
interface i2cm_in_if
    import i2cm_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2cm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick result channel
// Valid/ready channel that carries the pin levels and status of one tick.
// ----------------------------------------------------------------------------
interface i2cm_out_if
    import i2cm_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/i2c_command_transaction_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C command transaction master
// Pin-level I2C master that runs one bus half-period per item and sends a
// two-byte write or an address-plus-read-byte transaction.
// ----------------------------------------------------------------------------
//  channel    dir   handshake      payload
//  tick_in    in    valid/ready    start_req, command, command_word, sda_in
//  tick_out   out   valid/ready    scl, sda_level, sda_drive, busy_res,
//                                  done_res, read_byte
//
// One item per clock cycle; each result is registered and appears in the cycle after its item.
// The result comes from the sequencer register update, done in a single pass.
// The result register frees as it is taken, so ticks stream while tick_out
// is ready; a stall on tick_out holds tick_in off once the register is full.
// After reset the master is idle with SCL high and SDA released.
// ----------------------------------------------------------------------------
`include "i2c_command_transaction_master_defines.svh"

module i2c_command_transaction_master
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_in_if.sink     tick_in,
    i2cm_out_if.source  tick_out
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_ADDR  = 3'd2,
        PH_WDATA = 3'd3,
        PH_RDATA = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [4:0]        step_reg, step_next;
    logic [1:0]        sub_reg, sub_next;
    logic [2:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              is_read_reg, is_read_next;
    logic              scl_reg, scl_next;
    logic              sdal_reg, sdal_next;
    logic              sdad_reg, sdad_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;

    logic   accept;
    phase_t ph;
    logic [4:0] k;
    logic [7:0] wbyte;
    logic   last;

    logic   read_tick;
    logic   stop_tick;
    logic   stop_state;
    logic   idle_tick;

    assign tick_in.ready = !out_valid_reg || tick_out.ready;
    assign accept = tick_in.valid && tick_in.ready;

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        sub_next     = sub_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        word_next    = word_reg;
        is_read_next = is_read_reg;
        scl_next     = scl_reg;
        sdal_next    = sdal_reg;
        sdad_next    = sdad_reg;
        busy_next    = 1'b0;
        done_next    = 1'b0;
        last         = 1'b0;
        ph           = phase_reg;
        k            = step_reg;

        // A request taken while idle makes this tick the first START tick.
        if (phase_reg == PH_IDLE && tick_in.data.start_req)
        begin
            is_read_next = tick_in.data.command;
            word_next    = tick_in.data.command_word;
            ph           = PH_START;
            k            = 5'd0;
        end

        if (ph == PH_ADDR)
        begin
            wbyte = (8'(word_next[WORD_W-1:7]) & ADDR_MASK) | ADDR_BASE
                    | (is_read_next ? READ_FLAG : 8'h00);
        end
        else
        begin
            wbyte = word_next[7:0];
        end

        unique case (ph) inside
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_START:
            begin
                busy_next = 1'b1;
                if (k == 5'd0)
                begin
                    sdal_next = 1'b1;
                    sdad_next = 1'b1;
                end
                else if (k == 5'd1)
                begin
                    scl_next = 1'b1;
                end
                else if (k == 5'd2)
                begin
                    sdal_next = 1'b0;
                end
                else
                begin
                    scl_next = 1'b0;
                    last     = 1'b1;
                end
                phase_next = last ? PH_ADDR : PH_START;
            end
            PH_ADDR, PH_WDATA:
            begin
                busy_next = 1'b1;
                if (k == 5'd0)
                begin
                    sdad_next = 1'b1;
                    sub_next  = 2'd0;
                    bit_next  = 3'd0;
                end
                else if (k <= 5'd24)
                begin
                    // Each data bit takes three ticks: set SDA, SCL high, SCL low.
                    if (sub_reg == 2'd0)
                    begin
                        sdal_next = wbyte[~bit_reg];
                        scl_next  = 1'b0;
                    end
                    else if (sub_reg == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                    if (sub_reg == 2'd2)
                    begin
                        sub_next = 2'd0;
                        bit_next = bit_reg + 3'd1;
                    end
                    else
                    begin
                        sub_next = sub_reg + 2'd1;
                    end
                end
                else if (k == 5'd25)
                begin
                    sdad_next = 1'b0;
                    sdal_next = 1'b1;
                    scl_next  = 1'b0;
                end
                else if (k == 5'd26)
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    scl_next = 1'b0;
                    last     = 1'b1;
                end
                if (!last)
                begin
                    phase_next = ph;
                end
                else if (ph == PH_ADDR)
                begin
                    phase_next = is_read_next ? PH_RDATA : PH_WDATA;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_RDATA:
            begin
                busy_next = 1'b1;
                if (k == 5'd0)
                begin
                    sdal_next  = 1'b1;
                    sdad_next  = 1'b0;
                    shift_next = 8'h00;
                end
                else if (k <= 5'd16)
                begin
                    // Odd ticks raise SCL and sample the slave's data bit.
                    if (k[0])
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_reg[6:0], tick_in.data.sda_in};
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                else if (k == 5'd17)
                begin
                    sdal_next = 1'b1;
                    scl_next  = 1'b0;
                end
                else if (k == 5'd18)
                begin
                    scl_next = 1'b1;
                end
                else
                begin
                    scl_next = 1'b0;
                    last     = 1'b1;
                end
                phase_next = last ? PH_STOP : PH_RDATA;
            end
            PH_STOP:
            begin
                busy_next = 1'b1;
                if (k == 5'd0)
                begin
                    sdal_next = 1'b0;
                    sdad_next = 1'b1;
                end
                else if (k == 5'd1)
                begin
                    scl_next = 1'b1;
                end
                else if (k == 5'd2)
                begin
                    sdal_next = 1'b1;
                end
                else
                begin
                    sdad_next = 1'b0;
                    last      = 1'b1;
                    done_next = 1'b1;
                end
                phase_next = last ? PH_IDLE : PH_STOP;
            end
            default:
            begin
                phase_next = PH_IDLE;
                last       = 1'b1;
            end
        endcase

        if (ph == PH_IDLE)
        begin
            step_next = 5'd0;
        end
        else
        begin
            step_next = last ? 5'd0 : k + 5'd1;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (tick_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= 5'd0;
            sub_reg       <= 2'd0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'h00;
            word_reg      <= '0;
            is_read_reg   <= 1'b0;
            scl_reg       <= 1'b1;
            sdal_reg      <= 1'b1;
            sdad_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                step_reg    <= step_next;
                sub_reg     <= sub_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                word_reg    <= word_next;
                is_read_reg <= is_read_next;
                scl_reg     <= scl_next;
                sdal_reg    <= sdal_next;
                sdad_reg    <= sdad_next;
                busy_reg    <= busy_next;
                done_reg    <= done_next;
            end
        end
    end

    assign tick_out.valid          = out_valid_reg;
    assign tick_out.data.scl       = scl_reg;
    assign tick_out.data.sda_level = sdal_reg;
    assign tick_out.data.sda_drive = sdad_reg;
    assign tick_out.data.busy_res  = busy_reg;
    assign tick_out.data.done_res  = done_reg;
    assign tick_out.data.read_byte = shift_reg;

    assign read_tick  = phase_reg == PH_RDATA && step_reg != 5'd0;
    assign stop_tick  = accept && phase_reg == PH_STOP && step_reg == 5'd3;
    assign stop_state = phase_reg == PH_IDLE && done_reg && !sdad_reg;
    assign idle_tick  = accept && phase_reg == PH_IDLE && !tick_in.data.start_req;

    `I2CM_ASSERT_SAME(a_idle_step, phase_reg == PH_IDLE, step_reg == 5'd0, "nonzero idle step")
    `I2CM_ASSERT_SAME(a_read_releases_sda, read_tick, !sdad_reg, "SDA driven during read")
    `I2CM_ASSERT_NEXT(a_stop_ends, stop_tick, stop_state, "STOP did not finish the transaction")
    `I2CM_ASSERT_NEXT(a_idle_hold, idle_tick, $stable(shift_reg) && !busy_reg, "idle byte changed")

endmodule
